// File: sv/pes_pkg.sv
// Shared types and constants for the path ensemble statistics block.
`default_nettype none
package pes_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int PT_W       = 10;
  localparam int SUM_W      = 40;
  localparam int SQ_W       = 64;

  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_POINT   = 2'd1;
  localparam logic [1:0] CMD_SUMMARY = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  localparam logic [2:0] REG_PATH_COUNT = 3'd0;
  localparam logic [2:0] REG_LOWER      = 3'd1;
  localparam logic [2:0] REG_UPPER      = 3'd2;
  localparam logic [2:0] REG_TIMESTEP   = 3'd3;
  localparam logic [2:0] REG_CROSS_EN   = 3'd4;

  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] sample_value;
    logic               last_of_path;
    logic [9:0]         point_index;
  } pes_in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [23:0] point_mean;
    logic [45:0]        point_variance;
    logic [15:0]        above_crossings;
    logic [15:0]        below_crossings;
    logic [15:0]        total_crossings;
    logic [33:0]        mean_exit_time;
    logic               no_crossings;
    logic               index_out_of_range;
  } pes_out_t;

  typedef struct packed {
    logic              en;
    logic [PT_W-1:0]   addr;
    logic [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]   sq;
  } pes_wr_t;

endpackage
`default_nettype wire

// File: sv/pes_store.sv
// Per-point sum and square-sum memories with a clearing pass after reset.
`default_nettype none
module pes_store (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pes_pkg::pes_wr_t         wr,
  input  wire logic                     rd_en,
  input  wire logic [pes_pkg::PT_W-1:0] rd_addr,
  output logic [pes_pkg::SUM_W-1:0]     rd_sum,
  output logic [pes_pkg::SQ_W-1:0]      rd_sq,
  output logic                          busy
);
  import pes_pkg::*;

  logic [SUM_W-1:0] sum_mem [MAX_POINTS];
  logic [SQ_W-1:0]  sq_mem  [MAX_POINTS];
  logic [PT_W:0]    clr_r;

  assign busy = !clr_r[PT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (busy) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      sum_mem[clr_r[PT_W-1:0]] <= '0;
      sq_mem[clr_r[PT_W-1:0]]  <= '0;
    end else if (wr.en) begin
      sum_mem[wr.addr] <= wr.sum;
      sq_mem[wr.addr]  <= wr.sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sum <= sum_mem[rd_addr];
      rd_sq  <= sq_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/pes_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pes_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [79:0] dividend,
  input  wire logic [31:0] divisor,
  output logic [79:0]      quotient,
  output logic             done
);
  logic [79:0] dvd_r;
  logic [79:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] dsr_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] sh;
  logic        fit;

  assign sh  = {rem_r, dvd_r[79]};
  assign fit = sh >= {1'b0, dsr_r};
  assign quotient = quo_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[78:0], 1'b0};
        quo_r <= {quo_r[78:0], fit};
        rem_r <= fit ? 32'(sh - {1'b0, dsr_r}) : sh[31:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/path_ensemble_statistics.sv
// Top level: path ensemble mean, variance and first exit time.
//
// Items enter on in_valid/in_stall; results leave on out_valid/out_stall.
// Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data,
// cfg_ready is always high.
// A sample item reads memory, then adds and writes back. A point query
// reads memory, does six products on the shared 32x32 multiplier, then
// runs the serial divider for the mean and again for the variance, which is
// skipped if the variance term is negative. An out-of-range query goes
// straight to output. A crossing summary needs one multiply and one divider
// run unless there are no crossings. The block takes one item at a time; a
// finished result waits in the output register while following samples are
// accepted. After reset both memories are cleared, one entry a cycle, all
// 1024 entries; in_stall stays high meanwhile. A stalled result holds its
// value until taken; a new result waits for the output register to empty.
`default_nettype none
module path_ensemble_statistics (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pes_pkg::pes_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pes_pkg::pes_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [23:0]       cfg_data
);
  import pes_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SUPD, S_QRD, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
    S_DMEAN, S_DVAR, S_CMUL, S_CDIV, S_CWAIT, S_PUT
  } state_t;

  state_t state_r;

  logic [15:0]        path_count_r;
  logic signed [23:0] lower_r;
  logic signed [23:0] upper_r;
  logic [23:0]        timestep_r;
  logic               cross_en_r;

  logic [PT_W:0] step_r;
  logic [PT_W:0] path_len_r;
  logic          exited_r;
  logic [25:0]   esum_r;
  logic [15:0]   above_r;
  logic [15:0]   below_r;

  logic signed [23:0] x_r;
  logic [PT_W-1:0]    addr_r;
  logic [63:0]        prod_r;
  logic [79:0]        acc_r;
  logic [79:0]        a_r;
  logic [79:0]        diff_r;
  logic [31:0]        nn_r;
  logic [39:0]        mag_r;
  logic               neg_r;
  logic               var_zero_r;
  logic [16:0]        total_r;
  pes_out_t           res_r;
  pes_out_t           out_data_r;
  logic               out_valid_r;

  pes_wr_t          wr;
  logic             rd_en;
  logic [PT_W-1:0]  rd_addr;
  logic [SUM_W-1:0] rd_sum;
  logic [SQ_W-1:0]  rd_sq;
  logic             busy;

  logic        div_start;
  logic [79:0] div_dvd;
  logic [31:0] div_dsr;
  logic [79:0] div_q;
  logic        div_done;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [15:0] n;
  logic [23:0] in_mag;
  logic [39:0] sum_mag;
  logic        accept;
  logic [16:0] total;
  logic [26:0] esum_add;
  logic        hit_above;
  logic        hit_below;
  pes_out_t    res_init;

  assign n        = (path_count_r == '0) ? 16'd1 : path_count_r;
  assign in_mag   = in_data.sample_value[23] ? 24'(~in_data.sample_value + 1'b1)
                                             : in_data.sample_value;
  assign sum_mag  = rd_sum[39] ? 40'(~rd_sum + 1'b1) : rd_sum;
  assign in_stall = (state_r != S_IDLE) || busy;
  assign accept   = in_valid && !in_stall;
  assign total    = {1'b0, above_r} + {1'b0, below_r};
  assign esum_add = {1'b0, esum_r} + 27'(step_r);
  assign hit_above = cross_en_r && !exited_r && (in_data.sample_value > upper_r);
  assign hit_below = cross_en_r && !exited_r && !hit_above &&
                     (in_data.sample_value < lower_r);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pes_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_sum  (rd_sum),
    .rd_sq   (rd_sq),
    .busy    (busy)
  );

  pes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = step_r[PT_W-1:0];
    if (accept && in_data.command == CMD_SAMPLE && !step_r[PT_W]) begin
      rd_en = 1'b1;
    end else if (accept && in_data.command == CMD_POINT) begin
      rd_en   = 1'b1;
      rd_addr = in_data.point_index;
    end
  end

  always_comb begin
    res_init = '0;
    if (in_data.command == CMD_SUMMARY) begin
      res_init.result_kind     = KIND_SUMMARY;
      res_init.above_crossings = above_r;
      res_init.below_crossings = below_r;
      res_init.total_crossings = total[16] ? 16'hFFFF : total[15:0];
      res_init.no_crossings    = (total == '0);
    end else begin
      res_init.result_kind        = KIND_POINT;
      res_init.index_out_of_range = ({1'b0, in_data.point_index} >= path_len_r);
    end
  end

  always_comb begin
    wr.en   = (state_r == S_SUPD);
    wr.addr = addr_r;
    wr.sum  = rd_sum + {{16{x_r[23]}}, x_r};
    wr.sq   = rd_sq + {16'b0, prod_r[47:0]};
  end

  always_comb begin
    case (state_r)
      S_M1:    begin mul_a = {16'b0, n}; mul_b = rd_sq[31:0]; end
      S_M2:    begin mul_a = {16'b0, n}; mul_b = rd_sq[63:32]; end
      S_M3:    begin mul_a = mag_r[31:0]; mul_b = mag_r[31:0]; end
      S_M4:    begin mul_a = mag_r[31:0]; mul_b = {24'b0, mag_r[39:32]}; end
      S_M5:    begin mul_a = {24'b0, mag_r[39:32]}; mul_b = {24'b0, mag_r[39:32]}; end
      S_M6:    begin mul_a = {16'b0, n}; mul_b = {16'b0, n}; end
      S_CMUL:  begin mul_a = {6'b0, esum_r}; mul_b = {8'b0, timestep_r}; end
      default: begin mul_a = {8'b0, in_mag}; mul_b = {8'b0, in_mag}; end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {40'b0, mag_r};
    div_dsr   = {16'b0, n};
    case (state_r)
      S_M7:    div_start = 1'b1;
      S_DMEAN: begin
        div_start = div_done && !var_zero_r;
        div_dvd   = diff_r;
        div_dsr   = nn_r;
      end
      S_CDIV:  begin
        div_start = 1'b1;
        div_dvd   = {16'b0, prod_r};
        div_dsr   = {15'b0, total_r};
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_count_r <= 16'd1;
      lower_r      <= '0;
      upper_r      <= '0;
      timestep_r   <= 24'd65536;
      cross_en_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATH_COUNT: path_count_r <= cfg_data[15:0];
        REG_LOWER:      lower_r      <= cfg_data;
        REG_UPPER:      upper_r      <= cfg_data;
        REG_TIMESTEP:   timestep_r   <= cfg_data;
        REG_CROSS_EN:   cross_en_r   <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      path_len_r  <= '0;
      exited_r    <= 1'b0;
      esum_r      <= '0;
      above_r     <= '0;
      below_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_PUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_data.command)
              CMD_SAMPLE: begin
                x_r    <= in_data.sample_value;
                addr_r <= step_r[PT_W-1:0];
                if (!step_r[PT_W]) begin
                  state_r <= S_SUPD;
                  if (hit_above && above_r != 16'hFFFF) begin
                    above_r <= above_r + 1'b1;
                    esum_r  <= esum_add[26] ? '1 : esum_add[25:0];
                  end
                  if (hit_below && below_r != 16'hFFFF) begin
                    below_r <= below_r + 1'b1;
                    esum_r  <= esum_add[26] ? '1 : esum_add[25:0];
                  end
                  if (step_r + 1'b1 > path_len_r) begin
                    path_len_r <= step_r + 1'b1;
                  end
                end
                if (in_data.last_of_path) begin
                  step_r   <= '0;
                  exited_r <= 1'b0;
                end else if (!step_r[PT_W]) begin
                  step_r <= step_r + 1'b1;
                  if (hit_above || hit_below) begin
                    exited_r <= 1'b1;
                  end
                end
              end
              CMD_POINT: begin
                res_r <= res_init;
                if (res_init.index_out_of_range) begin
                  state_r <= S_PUT;
                end else begin
                  state_r <= S_QRD;
                end
              end
              CMD_SUMMARY: begin
                res_r   <= res_init;
                total_r <= total;
                if (total == '0) begin
                  state_r <= S_PUT;
                end else begin
                  state_r <= S_CMUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_SUPD: state_r <= S_IDLE;
        S_QRD: begin
          mag_r   <= sum_mag;
          neg_r   <= rd_sum[39];
          state_r <= S_M1;
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          acc_r   <= 80'(prod_r);
          state_r <= S_M3;
        end
        S_M3: begin
          acc_r   <= acc_r + (80'(prod_r) << 32);
          state_r <= S_M4;
        end
        S_M4: begin
          a_r     <= acc_r;
          acc_r   <= 80'(prod_r);
          state_r <= S_M5;
        end
        S_M5: begin
          acc_r   <= acc_r + (80'(prod_r) << 33);
          state_r <= S_M6;
        end
        S_M6: begin
          acc_r   <= acc_r + (80'(prod_r) << 64);
          state_r <= S_M7;
        end
        S_M7: begin
          nn_r       <= prod_r[31:0];
          var_zero_r <= a_r < acc_r;
          diff_r     <= a_r - acc_r;
          state_r    <= S_DMEAN;
        end
        S_DMEAN: begin
          if (div_done) begin
            if (neg_r) begin
              res_r.point_mean <= (div_q > 80'd8388608) ? 24'sh800000
                                                         : 24'(-div_q[23:0]);
            end else begin
              res_r.point_mean <= (div_q > 80'd8388607) ? 24'sh7FFFFF
                                                         : div_q[23:0];
            end
            state_r <= var_zero_r ? S_PUT : S_DVAR;
          end
        end
        S_DVAR: begin
          if (div_done) begin
            res_r.point_variance <= (div_q[79:46] != '0) ? '1 : div_q[45:0];
            state_r <= S_PUT;
          end
        end
        S_CMUL: state_r <= S_CDIV;
        S_CDIV: state_r <= S_CWAIT;
        S_CWAIT: begin
          if (div_done) begin
            res_r.mean_exit_time <= (div_q[79:34] != '0) ? '1 : div_q[33:0];
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
